### sv/pwc_pkg.sv
`default_nettype none
package pwc_pkg;

  // Timer width and the widths of the register and stream fields
  localparam int TIMER_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int ECHO_W     = 15;
  localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // APB register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam logic [IDX_W-1:0] REG_SLEEP      = 3'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW     = 3'd1;
  localparam logic [IDX_W-1:0] REG_INTERVAL   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFF_DELAY  = 3'd3;
  localparam logic [IDX_W-1:0] REG_NEAR_LIMIT = 3'd4;

  // Register reset values
  localparam logic [CFG_W-1:0]  SLEEP_RST      = 16'd20000;
  localparam logic [CFG_W-1:0]  WINDOW_RST     = 16'd5000;
  localparam logic [CFG_W-1:0]  INTERVAL_RST   = 16'd500;
  localparam logic [CFG_W-1:0]  OFF_DELAY_RST  = 16'd10000;
  localparam logic [ECHO_W-1:0] NEAR_LIMIT_RST = 15'd2916;

  // Mode codes as reported on the result stream
  localparam logic [1:0] MODE_CODE_SLEEP  = 2'd0;
  localparam logic [1:0] MODE_CODE_SENSE  = 2'd1;
  localparam logic [1:0] MODE_CODE_ACTIVE = 2'd2;

  // Stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [2:0] {
    MODE_SLEEP  = 3'b001,
    MODE_SENSE  = 3'b010,
    MODE_ACTIVE = 3'b100
  } mode_t;

  typedef struct packed {
    logic [CFG_W-1:0]  sleep_ms;
    logic [CFG_W-1:0]  window_ms;
    logic [CFG_W-1:0]  interval_ms;
    logic [CFG_W-1:0]  off_delay_ms;
    logic [ECHO_W-1:0] near_limit_us;
  } cfg_t;

  typedef struct packed {
    logic       radio_enable;
    logic       report_valid;
    logic       object_near;
    logic       sample_taken;
    logic [1:0] mode;
  } result_t;

endpackage
`default_nettype wire

### sv/pwc_cfg.sv
`default_nettype none
module pwc_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [pwc_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [pwc_pkg::DATA_W-1:0] cfg_pwdata,
  output      logic [pwc_pkg::DATA_W-1:0] cfg_prdata,
  output      logic                       cfg_pready,
  output      pwc_pkg::cfg_t              cfg
);

  pwc_pkg::cfg_t            cfg_r;
  logic                     wr_en;
  logic [pwc_pkg::IDX_W-1:0] idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[pwc_pkg::ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  // Write the addressed register; addresses past the map are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sleep_ms      <= pwc_pkg::SLEEP_RST;
      cfg_r.window_ms     <= pwc_pkg::WINDOW_RST;
      cfg_r.interval_ms   <= pwc_pkg::INTERVAL_RST;
      cfg_r.off_delay_ms  <= pwc_pkg::OFF_DELAY_RST;
      cfg_r.near_limit_us <= pwc_pkg::NEAR_LIMIT_RST;
    end else if (wr_en) begin
      case (idx)
        pwc_pkg::REG_SLEEP:      cfg_r.sleep_ms      <= cfg_pwdata[pwc_pkg::CFG_W-1:0];
        pwc_pkg::REG_WINDOW:     cfg_r.window_ms     <= cfg_pwdata[pwc_pkg::CFG_W-1:0];
        pwc_pkg::REG_INTERVAL:   cfg_r.interval_ms   <= cfg_pwdata[pwc_pkg::CFG_W-1:0];
        pwc_pkg::REG_OFF_DELAY:  cfg_r.off_delay_ms  <= cfg_pwdata[pwc_pkg::CFG_W-1:0];
        pwc_pkg::REG_NEAR_LIMIT: cfg_r.near_limit_us <= cfg_pwdata[pwc_pkg::ECHO_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      pwc_pkg::REG_SLEEP:      cfg_prdata = pwc_pkg::DATA_W'(cfg_r.sleep_ms);
      pwc_pkg::REG_WINDOW:     cfg_prdata = pwc_pkg::DATA_W'(cfg_r.window_ms);
      pwc_pkg::REG_INTERVAL:   cfg_prdata = pwc_pkg::DATA_W'(cfg_r.interval_ms);
      pwc_pkg::REG_OFF_DELAY:  cfg_prdata = pwc_pkg::DATA_W'(cfg_r.off_delay_ms);
      pwc_pkg::REG_NEAR_LIMIT: cfg_prdata = pwc_pkg::DATA_W'(cfg_r.near_limit_us);
      default:                 cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### sv/pwc_core.sv
`default_nettype none
module pwc_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic [pwc_pkg::ECHO_W-1:0] echo_us,
  input  wire pwc_pkg::cfg_t              cfg,
  output      pwc_pkg::result_t           res
);

  pwc_pkg::mode_t                 mode_r, mode_nxt;
  logic [pwc_pkg::TIMER_BITS-1:0] mode_el_r, mode_el_nxt;
  logic [pwc_pkg::TIMER_BITS-1:0] since_r, since_nxt;
  logic                           far_cnt_r, far_cnt_nxt;
  logic [pwc_pkg::TIMER_BITS-1:0] far_el_r, far_el_nxt;

  pwc_pkg::mode_t                 mode_x;
  logic [pwc_pkg::TIMER_BITS-1:0] mode_el_x, since_x, far_el_x;
  logic                           far_cnt_x;
  logic                           near, wake, sample_due;

  function automatic logic [pwc_pkg::TIMER_BITS-1:0] sat_inc(
    input logic [pwc_pkg::TIMER_BITS-1:0] v
  );
    return (v == pwc_pkg::TIMER_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic at_least(
    input logic [pwc_pkg::TIMER_BITS-1:0] t,
    input logic [pwc_pkg::CFG_W-1:0]      lim
  );
    return pwc_pkg::CMP_W'(t) >= pwc_pkg::CMP_W'(lim);
  endfunction

  assign near = (echo_us != '0) && (echo_us < cfg.near_limit_us);
  assign wake = (mode_r == pwc_pkg::MODE_SLEEP) && at_least(mode_el_r, cfg.sleep_ms);

  // Evaluate one tick: wake-up, sampling, mode change, then timer advance
  always_comb begin
    mode_x    = wake ? pwc_pkg::MODE_SENSE : mode_r;
    mode_el_x = wake ? '0 : mode_el_r;
    since_x   = wake ? pwc_pkg::TIMER_MAX : since_r;
    far_cnt_x = wake ? 1'b0 : far_cnt_r;
    far_el_x  = wake ? '0 : far_el_r;
    sample_due = at_least(since_x, cfg.interval_ms);
    res = '0;

    case (mode_x)
      pwc_pkg::MODE_SLEEP: begin
        res.mode = pwc_pkg::MODE_CODE_SLEEP;
      end
      pwc_pkg::MODE_SENSE: begin
        res.mode = pwc_pkg::MODE_CODE_SENSE;
        if (sample_due) begin
          res.sample_taken = 1'b1;
          res.object_near  = near;
          since_x          = '0;
        end
        if (sample_due && near) begin
          mode_x    = pwc_pkg::MODE_ACTIVE;
          mode_el_x = '0;
          far_cnt_x = 1'b0;
          far_el_x  = '0;
        end else if (at_least(mode_el_x, cfg.window_ms)) begin
          mode_x    = pwc_pkg::MODE_SLEEP;
          mode_el_x = '0;
          far_cnt_x = 1'b0;
          far_el_x  = '0;
        end
      end
      pwc_pkg::MODE_ACTIVE: begin
        res.mode         = pwc_pkg::MODE_CODE_ACTIVE;
        res.radio_enable = 1'b1;
        if (sample_due) begin
          res.sample_taken = 1'b1;
          res.object_near  = near;
          res.report_valid = 1'b1;
          since_x          = '0;
          if (near) begin
            far_cnt_x = 1'b0;
            far_el_x  = '0;
          end else if (!far_cnt_x) begin
            far_cnt_x = 1'b1;
            far_el_x  = '0;
          end else if (at_least(far_el_x, cfg.off_delay_ms)) begin
            mode_x    = pwc_pkg::MODE_SLEEP;
            mode_el_x = '0;
            far_cnt_x = 1'b0;
            far_el_x  = '0;
          end
        end
      end
      default: begin
        // Unknown mode: fall into sleep and report as sleep
        res.mode  = pwc_pkg::MODE_CODE_SLEEP;
        mode_x    = pwc_pkg::MODE_SLEEP;
        mode_el_x = '0;
        far_cnt_x = 1'b0;
        far_el_x  = '0;
      end
    endcase

    mode_nxt    = mode_x;
    mode_el_nxt = sat_inc(mode_el_x);
    since_nxt   = sat_inc(since_x);
    far_cnt_nxt = far_cnt_x;
    far_el_nxt  = far_cnt_x ? sat_inc(far_el_x) : far_el_x;
  end

  // Advance the state once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= pwc_pkg::MODE_SENSE;
      mode_el_r <= '0;
      since_r   <= pwc_pkg::TIMER_MAX;
      far_cnt_r <= 1'b0;
      far_el_r  <= '0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      mode_el_r <= mode_el_nxt;
      since_r   <= since_nxt;
      far_cnt_r <= far_cnt_nxt;
      far_el_r  <= far_el_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/proximity_wake_power_controller_unit.sv
// An accepted request waits in the input register; its result is registered to out_tdata.
// Throughput: one request per cycle while out_tready stays high; the input register and
// the result register each take a new request whenever the next stage frees up in the
// same cycle.
// Reset (rst_n low, synchronous): pipeline empties, registers return to defaults, the
// controller starts in the sensing window with the first sample due at once.
`default_nettype none
module proximity_wake_power_controller_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata: [14:0] echo_us, [15] zero
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [pwc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [1:0] mode, [2] sample_taken, [3] object_near, [4] report_valid,
  // [5] radio_enable, [7:6] zero
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [pwc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [pwc_pkg::ADDR_W-1:0]      cfg_paddr,
  input  wire logic [pwc_pkg::DATA_W-1:0]      cfg_pwdata,
  output      logic [pwc_pkg::DATA_W-1:0]      cfg_prdata,
  output      logic                            cfg_pready
);

  pwc_pkg::cfg_t                  cfg;
  pwc_pkg::result_t               res;
  pwc_pkg::result_t               out_res_r;
  logic                           s1_valid_r, s1_valid_nxt;
  logic [pwc_pkg::ECHO_W-1:0]     s1_echo_r;
  logic                           out_valid_r, out_valid_nxt;
  logic                           advance;

  pwc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pwc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .echo_us (s1_echo_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Move the held request into the result register when that slot is free
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_echo_r <= in_tdata[pwc_pkg::ECHO_W-1:0];
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pwc_pkg::OUT_TDATA_W'(out_res_r);

  // A report is always a sample taken with the radio on
  a_report_sampled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.report_valid |-> out_res_r.sample_taken && out_res_r.radio_enable)
    else $error("report without sample in active mode");

  // A near flag needs a sample on the same tick
  a_near_sampled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.object_near |-> out_res_r.sample_taken)
    else $error("near flag without sample");

  // Radio is on exactly in active mode
  a_radio_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_res_r.radio_enable == (out_res_r.mode == pwc_pkg::MODE_CODE_ACTIVE))
    else $error("radio state disagrees with mode");

  // A request reaches the result register in the cycle after it leaves the input stage
  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded after advance");

endmodule
`default_nettype wire
